@@ rtl/core/occ_pkg.sv @@
// shared types and constants of the order crossing match engine
`default_nettype none
package occ_pkg;

  localparam int unsigned ORDER_SLOTS_DEF = 16;
  localparam int unsigned MAX_SALES       = 32;
  localparam int unsigned SALE_CNT_W      = $clog2(MAX_SALES + 1);
  localparam int unsigned VAL_W           = 32;

  localparam logic [1:0] MODE_ASK = 2'd0;
  localparam logic [1:0] MODE_BID = 2'd1;
  localparam logic [1:0] MODE_RUN = 2'd2;

  localparam logic CFG_PRODUCT = 1'b0;
  localparam logic CFG_TIME    = 1'b1;

  localparam logic KIND_ASK = 1'b0;
  localparam logic KIND_BID = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ASK,
    S_MATCH,
    S_FIN
  } occ_state_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       product_id;
    logic [31:0]      time_id;
    logic [VAL_W-1:0] price;
    logic [VAL_W-1:0] amount;
    logic             sim_user;
  } in_t;

  typedef struct packed {
    logic             sale_valid;
    logic [VAL_W-1:0] sale_price;
    logic [VAL_W-1:0] sale_amount;
    logic             sale_kind;
    logic             sale_sim_user;
    logic             last;
    logic             overflow;
  } out_t;

  // one stored order
  typedef struct packed {
    logic [VAL_W-1:0] price;
    logic [VAL_W-1:0] amount;
    logic             sim;
  } ord_t;

  // operands of the shared compare and subtract unit
  typedef struct packed {
    logic [VAL_W-1:0] ask_price;
    logic [VAL_W-1:0] bid_price;
    logic [VAL_W-1:0] ask_amt;
    logic [VAL_W-1:0] bid_amt;
  } alu_in_t;

  typedef struct packed {
    logic             price_ok;
    logic             b_ge_a;
    logic             b_nz;
    logic [VAL_W-1:0] rem_bid;
    logic [VAL_W-1:0] rem_ask;
  } alu_out_t;

endpackage
`default_nettype wire

@@ rtl/core/occ_book.sv @@
// price sorted order store for one side of the book
`default_nettype none
module occ_book #(
  parameter int unsigned SLOTS = 16,
  parameter bit          DESC  = 1'b0,
  localparam int unsigned CW = $clog2(SLOTS + 1),
  localparam int unsigned IW = $clog2(SLOTS)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          ld_en_i,
  input  wire occ_pkg::ord_t ld_i,
  input  wire logic          clr_i,
  input  wire logic          wr_en_i,
  input  wire logic [IW-1:0] wr_idx_i,
  input  wire logic [31:0]   wr_amt_i,
  input  wire logic [IW-1:0] rd_idx_i,
  output occ_pkg::ord_t      rd_o,
  output logic [CW-1:0]      count_o,
  output logic               full_o
);
  import occ_pkg::*;

  ord_t          cells_q [SLOTS];
  logic [CW-1:0] count_q, count_d;
  logic [SLOTS-1:0] shift;
  logic [SLOTS-1:0] take_new;

  // per cell: does this entry move up to make room
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      if (DESC) begin
        shift[i] = (CW'(i) < count_q) && (cells_q[i].price < ld_i.price);
      end else begin
        shift[i] = (CW'(i) < count_q) && (cells_q[i].price > ld_i.price);
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      take_new[i] = (CW'(i) <= count_q) && ((CW'(i) == count_q) || shift[i]) &&
                    ((i == 0) || !shift[(i == 0) ? 0 : i - 1]);
    end
  end

  assign full_o  = (count_q == CW'(SLOTS));
  assign count_o = count_q;
  assign rd_o    = cells_q[rd_idx_i];

  // count of stored orders
  always_comb begin
    count_d = count_q;
    if (clr_i) begin
      count_d = '0;
    end else if (ld_en_i && !full_o) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // insertion with shift, and amount updates during matching
  always_ff @(posedge clk_i) begin
    if (ld_en_i && !full_o) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (take_new[i]) begin
          cells_q[i] <= ld_i;
        end else if ((i > 0) && shift[(i == 0) ? 0 : i - 1]) begin
          cells_q[i] <= cells_q[(i == 0) ? 0 : i - 1];
        end
      end
    end else if (wr_en_i) begin
      cells_q[wr_idx_i].amount <= wr_amt_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/occ_alu.sv @@
// shared compare and subtract unit used by every matching step
`default_nettype none
module occ_alu (
  input  wire occ_pkg::alu_in_t a_i,
  output occ_pkg::alu_out_t     r_o
);
  import occ_pkg::*;

  logic [VAL_W:0] diff;

  // bid minus ask amount, borrow tells which side is larger
  always_comb begin
    diff           = {1'b0, a_i.bid_amt} - {1'b0, a_i.ask_amt};
    r_o.price_ok   = (a_i.bid_price >= a_i.ask_price);
    r_o.b_ge_a     = !diff[VAL_W];
    r_o.b_nz       = (a_i.bid_amt != '0);
    r_o.rem_bid    = diff[VAL_W-1:0];
    r_o.rem_ask    = VAL_W'(0) - diff[VAL_W-1:0];
  end

endmodule
`default_nettype wire

@@ rtl/core/occ_seq.sv @@
// matching sequencer with pending sale and output register
`default_nettype none
module occ_seq #(
  parameter int unsigned SLOTS = 16,
  localparam int unsigned CW = $clog2(SLOTS + 1),
  localparam int unsigned IW = $clog2(SLOTS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              overflow_i,
  input  wire logic [CW-1:0]     ask_cnt_i,
  input  wire logic [CW-1:0]     bid_cnt_i,
  input  wire occ_pkg::ord_t     ask_i,
  input  wire occ_pkg::ord_t     bid_i,
  input  wire occ_pkg::alu_out_t alu_i,
  output occ_pkg::alu_in_t       alu_o,
  output logic [IW-1:0]          ask_idx_o,
  output logic [IW-1:0]          bid_idx_o,
  output logic                   bid_wr_o,
  output logic [31:0]            bid_amt_o,
  output logic                   clr_o,
  output logic                   idle_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output occ_pkg::out_t          out_data_o
);
  import occ_pkg::*;

  occ_state_e            state_q, state_d;
  logic [CW-1:0]         i_q, i_d, j_q, j_d;
  logic [VAL_W-1:0]      aamt_q, aamt_d;
  logic [SALE_CNT_W-1:0] nsale_q, nsale_d;
  logic                  pend_v_q, pend_v_d, out_v_q, out_v_d;
  out_t                  pend_q, pend_d, out_q, out_d;
  out_t                  sale;
  logic                  out_free;

  assign ask_idx_o   = i_q[IW-1:0];
  assign bid_idx_o   = j_q[IW-1:0];
  assign idle_o      = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_v_q || out_ready_i;

  // operands for the shared unit
  always_comb begin
    alu_o.ask_price = ask_i.price;
    alu_o.bid_price = bid_i.price;
    alu_o.ask_amt   = aamt_q;
    alu_o.bid_amt   = bid_i.amount;
  end

  // sale built from the current pair
  always_comb begin
    sale.sale_valid    = 1'b1;
    sale.sale_price    = ask_i.price;
    sale.sale_amount   = alu_i.b_ge_a ? aamt_q : bid_i.amount;
    sale.sale_kind     = (bid_i.sim && !ask_i.sim) ? KIND_BID : KIND_ASK;
    sale.sale_sim_user = bid_i.sim | ask_i.sim;
    sale.last          = 1'b0;
    sale.overflow      = overflow_i;
  end

  // next state and outputs
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    aamt_d    = aamt_q;
    nsale_d   = nsale_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    out_v_d   = out_v_q && !out_ready_i;
    out_d     = out_q;
    bid_wr_o  = 1'b0;
    bid_amt_o = alu_i.rem_bid;
    clr_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          i_d     = '0;
          nsale_d = '0;
          state_d = S_ASK;
        end
      end
      S_ASK: begin
        if (i_q >= ask_cnt_i) begin
          state_d = S_FIN;
        end else begin
          aamt_d  = ask_i.amount;
          j_d     = '0;
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        if ((j_q >= bid_cnt_i) || !alu_i.price_ok) begin
          // no more bids reach this ask
          i_d     = i_q + CW'(1);
          state_d = S_ASK;
        end else if (alu_i.b_ge_a || alu_i.b_nz) begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_d   = pend_q;
              out_v_d = 1'b1;
            end
            pend_d   = sale;
            pend_v_d = 1'b1;
            nsale_d  = nsale_q + SALE_CNT_W'(1);
            bid_wr_o = 1'b1;
            if (alu_i.b_ge_a) begin
              bid_amt_o = alu_i.rem_bid;
              i_d       = i_q + CW'(1);
              state_d   = S_ASK;
            end else begin
              bid_amt_o = '0;
              aamt_d    = alu_i.rem_ask;
              j_d       = j_q + CW'(1);
            end
            if (nsale_q + SALE_CNT_W'(1) == SALE_CNT_W'(MAX_SALES)) begin
              state_d = S_FIN;
            end
          end
        end else begin
          // exhausted bid, skip it
          j_d = j_q + CW'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          if (pend_v_q) begin
            out_d = pend_q;
          end else begin
            out_d          = '0;
            out_d.overflow = overflow_i;
          end
          out_d.last = 1'b1;
          out_v_d    = 1'b1;
          pend_v_d   = 1'b0;
          clr_o      = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      nsale_q  <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      nsale_q  <= nsale_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    aamt_q <= aamt_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

endmodule
`default_nettype wire

@@ rtl/core/order_crossing_match_engine_top.sv @@
// top level of the order crossing match engine
// a load item is taken back to back while idle
// a run item keeps the input busy until the run ends, the shared compare and subtract
// unit stepping one pair a cycle unless a sale waits on a stalled output
// reset: counts, overflow flag, config and output valid clear at once
`default_nettype none
module order_crossing_match_engine_top #(
  parameter int unsigned ORDER_SLOTS = occ_pkg::ORDER_SLOTS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire occ_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output occ_pkg::out_t     out_data_o
);
  import occ_pkg::*;

  localparam int unsigned CW = $clog2(ORDER_SLOTS + 1);
  localparam int unsigned IW = $clog2(ORDER_SLOTS);

  logic [7:0]    product_q;
  logic [31:0]   time_q;
  logic          ovf_q;
  logic          accept, mine, ld_ask, ld_bid, start, clr, idle;
  logic          ask_full, bid_full, bid_wr;
  logic [CW-1:0] ask_cnt, bid_cnt;
  logic [IW-1:0] ask_idx, bid_idx;
  logic [31:0]   bid_amt;
  ord_t          ld, ask_rd, bid_rd;
  alu_in_t       alu_in;
  alu_out_t      alu_out;

  assign in_ready_o = idle;
  assign accept     = in_valid_i && in_ready_o;
  assign mine       = (in_data_i.product_id == product_q) && (in_data_i.time_id == time_q);
  assign ld_ask     = accept && mine && (in_data_i.mode == MODE_ASK);
  assign ld_bid     = accept && mine && (in_data_i.mode == MODE_BID);
  assign start      = accept && (in_data_i.mode == MODE_RUN);

  always_comb begin
    ld.price  = in_data_i.price;
    ld.amount = in_data_i.amount;
    ld.sim    = in_data_i.sim_user;
  end

  // config registers and sticky overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      product_q <= '0;
      time_q    <= '0;
      ovf_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PRODUCT: product_q <= cfg_data_i[7:0];
          CFG_TIME:    time_q    <= cfg_data_i;
          default:     ;
        endcase
      end
      if ((ld_ask && ask_full) || (ld_bid && bid_full)) begin
        ovf_q <= 1'b1;
      end
    end
  end

  occ_book #(.SLOTS(ORDER_SLOTS), .DESC(1'b0)) u_asks (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ld_en_i  (ld_ask),
    .ld_i     (ld),
    .clr_i    (clr),
    .wr_en_i  (1'b0),
    .wr_idx_i (ask_idx),
    .wr_amt_i (bid_amt),
    .rd_idx_i (ask_idx),
    .rd_o     (ask_rd),
    .count_o  (ask_cnt),
    .full_o   (ask_full)
  );

  occ_book #(.SLOTS(ORDER_SLOTS), .DESC(1'b1)) u_bids (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ld_en_i  (ld_bid),
    .ld_i     (ld),
    .clr_i    (clr),
    .wr_en_i  (bid_wr),
    .wr_idx_i (bid_idx),
    .wr_amt_i (bid_amt),
    .rd_idx_i (bid_idx),
    .rd_o     (bid_rd),
    .count_o  (bid_cnt),
    .full_o   (bid_full)
  );

  occ_alu u_alu (
    .a_i (alu_in),
    .r_o (alu_out)
  );

  occ_seq #(.SLOTS(ORDER_SLOTS)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .overflow_i  (ovf_q),
    .ask_cnt_i   (ask_cnt),
    .bid_cnt_i   (bid_cnt),
    .ask_i       (ask_rd),
    .bid_i       (bid_rd),
    .alu_i       (alu_out),
    .alu_o       (alu_in),
    .ask_idx_o   (ask_idx),
    .bid_idx_o   (bid_idx),
    .bid_wr_o    (bid_wr),
    .bid_amt_o   (bid_amt),
    .clr_o       (clr),
    .idle_o      (idle),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

@@ rtl/core/occ_checker.sv @@
// port level checks of the match engine and their binding
`default_nettype none
module occ_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire occ_pkg::out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // an empty run result is always the last one
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.sale_valid |-> out_data_o.last)
    else $error("empty result without last");

  // an empty run result carries zero price and amount
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.sale_valid |->
      (out_data_o.sale_price == '0) && (out_data_o.sale_amount == '0))
    else $error("empty result with data");

  // while a run is still producing sales no new item is taken
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("item taken in the middle of a run");

endmodule

bind order_crossing_match_engine_top occ_checker u_occ_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

@@ tb/sv/order_crossing_match_engine_top_test.sv @@
// self-checking testbench of the order crossing match engine
module order_crossing_match_engine_top_test;
  import occ_pkg::*;

  localparam int unsigned SLOTS = ORDER_SLOTS_DEF;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  // book model and queue of predicted sales
  class sale_scoreboard;
    logic [7:0]  tgt_product;
    logic [31:0] tgt_time;
    logic [31:0] ask_px[SLOTS];
    logic [31:0] ask_qty[SLOTS];
    logic        ask_sim[SLOTS];
    logic [31:0] bid_px[SLOTS];
    logic [31:0] bid_qty[SLOTS];
    logic        bid_sim[SLOTS];
    int          n_asks;
    int          n_bids;
    logic        ovf_flag;
    out_t        sales_due[$];
    int          errors;

    function void clear_book();
      tgt_product = '0;
      tgt_time = '0;
      n_asks = 0;
      n_bids = 0;
      ovf_flag = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == CFG_PRODUCT) tgt_product = val[7:0];
      else tgt_time = val;
    endfunction

    function void push_sale(logic v, logic [31:0] px, logic [31:0] qty, logic k,
                            logic s);
      out_t r;
      r.sale_valid = v;
      r.sale_price = px;
      r.sale_amount = qty;
      r.sale_kind = k;
      r.sale_sim_user = s;
      r.last = 1'b0;
      r.overflow = ovf_flag;
      sales_due = {sales_due, r};
    endfunction

    // note an accepted input item and predict its sales
    function void note_order(in_t it);
      int aord[SLOTS];
      int bord[SLOTS];
      logic [31:0] brem[SLOTS];
      logic [31:0] arem;
      int i, j, t, n, a, b;
      logic k, s;
      if (it.mode == MODE_ASK || it.mode == MODE_BID) begin
        if (it.product_id != tgt_product || it.time_id != tgt_time) return;
        if (it.mode == MODE_ASK) begin
          if (n_asks >= SLOTS) begin
            ovf_flag = 1'b1;
            return;
          end
          ask_px[n_asks] = it.price;
          ask_qty[n_asks] = it.amount;
          ask_sim[n_asks] = it.sim_user;
          n_asks++;
        end else begin
          if (n_bids >= SLOTS) begin
            ovf_flag = 1'b1;
            return;
          end
          bid_px[n_bids] = it.price;
          bid_qty[n_bids] = it.amount;
          bid_sim[n_bids] = it.sim_user;
          n_bids++;
        end
        return;
      end
      if (it.mode != MODE_RUN) return;
      // stable insertion sorts
      for (i = 0; i < n_asks; i++) aord[i] = i;
      for (i = 0; i < n_bids; i++) begin
        bord[i] = i;
        brem[i] = bid_qty[i];
      end
      for (i = 1; i < n_asks; i++) begin
        t = aord[i];
        j = i;
        while (j > 0 && ask_px[aord[j-1]] > ask_px[t]) begin
          aord[j] = aord[j-1];
          j--;
        end
        aord[j] = t;
      end
      for (i = 1; i < n_bids; i++) begin
        t = bord[i];
        j = i;
        while (j > 0 && bid_px[bord[j-1]] < bid_px[t]) begin
          bord[j] = bord[j-1];
          j--;
        end
        bord[j] = t;
      end
      n = 0;
      for (i = 0; i < n_asks && n < MAX_SALES; i++) begin
        a = aord[i];
        arem = ask_qty[a];
        for (j = 0; j < n_bids && n < MAX_SALES; j++) begin
          b = bord[j];
          if (bid_px[b] < ask_px[a]) continue;
          k = ask_sim[a] ? KIND_ASK : (bid_sim[b] ? KIND_BID : KIND_ASK);
          s = ask_sim[a] | bid_sim[b];
          if (brem[b] >= arem) begin
            push_sale(1'b1, ask_px[a], arem, k, s);
            n++;
            brem[b] -= arem;
            break;
          end
          if (brem[b] != 0) begin
            push_sale(1'b1, ask_px[a], brem[b], k, s);
            n++;
            arem -= brem[b];
            brem[b] = '0;
          end
        end
      end
      n_asks = 0;
      n_bids = 0;
      if (n == 0) push_sale(1'b0, '0, '0, KIND_ASK, 1'b0);
      sales_due[$].last = 1'b1;
    endfunction

    // compare one result with the oldest prediction
    function void check_sale(out_t got);
      out_t w;
      if (sales_due.size() == 0) begin
        $error("unexpected sale %p", got);
        errors++;
        return;
      end
      w = sales_due.pop_front();
      if (got.sale_valid !== w.sale_valid) begin
        $error("sale_valid exp %0h got %0h", w.sale_valid, got.sale_valid); errors++;
      end
      if (got.sale_price !== w.sale_price) begin
        $error("sale_price exp %0h got %0h", w.sale_price, got.sale_price); errors++;
      end
      if (got.sale_amount !== w.sale_amount) begin
        $error("sale_amount exp %0h got %0h", w.sale_amount, got.sale_amount); errors++;
      end
      if (got.sale_kind !== w.sale_kind) begin
        $error("sale_kind exp %0h got %0h", w.sale_kind, got.sale_kind); errors++;
      end
      if (got.sale_sim_user !== w.sale_sim_user) begin
        $error("sale_sim_user exp %0h got %0h", w.sale_sim_user, got.sale_sim_user);
        errors++;
      end
      if (got.last !== w.last) begin
        $error("last exp %0h got %0h", w.last, got.last); errors++;
      end
      if (got.overflow !== w.overflow) begin
        $error("overflow exp %0h got %0h", w.overflow, got.overflow); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;

  sale_scoreboard book = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 1'b0;
  int idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  order_crossing_match_engine_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // note accepted items, check results and drive receiver readiness
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) book.note_order(in_data_i);
      if (out_valid_o && out_ready_i) book.check_sale(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      out_ready_i <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAIL order_crossing_match_engine_top");
      $finish;
    end
  end

  task automatic cfg_write(logic idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    book.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offer one item, hold until taken, with random leading gaps
  // valid stays high after the taking edge until the next gap or stop
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (book.sales_due.size() != 0) @(posedge clk_i);
    repeat (SLOTS * (SLOTS + 1) + 10) @(posedge clk_i);
  endtask

  function automatic in_t make_order(logic [1:0] m, logic [31:0] px, logic [31:0] qty,
                                     logic s);
    in_t it;
    it.mode = m;
    it.product_id = book.tgt_product;
    it.time_id = book.tgt_time;
    it.price = px;
    it.amount = qty;
    it.sim_user = s;
    return it;
  endfunction

  function automatic in_t rand_order();
    in_t it;
    int r;
    r = $urandom_range(99);
    it = make_order((r < 50) ? MODE_ASK : MODE_BID,
                    ($urandom_range(3) == 0) ? $urandom : 32'h10000 * $urandom_range(8),
                    ($urandom_range(5) == 0) ? $urandom_range(1)
                      : (($urandom_range(4) == 0) ? $urandom : $urandom_range(9) << 16),
                    1'($urandom_range(1)));
    if (r >= 90) begin
      // foreign or unused-mode noise
      it.product_id = 8'($urandom);
      it.time_id = ($urandom_range(1) != 0) ? $urandom : book.tgt_time;
      if (r >= 97) it.mode = MODE_UNUSED;
    end
    return it;
  endfunction

  // one book of random orders then a run
  task automatic rand_batch(int n_orders);
    for (int i = 0; i < n_orders; i++) send_item(rand_order());
    send_item(make_order(MODE_RUN, $urandom, $urandom, 1'($urandom_range(1))));
  endtask

  initial begin
    int sent;
    book.clear_book();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zeros, ties, empty run
    cfg_write(CFG_PRODUCT, 32'hFF);
    cfg_write(CFG_TIME, 32'hFFFF_FFFF);
    send_item(make_order(MODE_RUN, '0, '0, 1'b0));
    send_item(make_order(MODE_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_item(make_order(MODE_ASK, '0, '0, 1'b0));
    send_item(make_order(MODE_ASK, 32'h0001_0000, 32'h0003_0000, 1'b0));
    send_item(make_order(MODE_ASK, 32'h0001_0000, 32'h0001_0000, 1'b0));
    send_item(make_order(MODE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_item(make_order(MODE_BID, 32'h0002_0000, '0, 1'b1));
    send_item(make_order(MODE_BID, 32'h0002_0000, 32'h0001_0000, 1'b1));
    send_item(make_order(MODE_BID, '0, '0, 1'b0));
    begin
      in_t f;
      f = make_order(MODE_BID, 32'h5, 32'h5, 1'b0);
      f.product_id = 8'h00;
      send_item(f);
      f = make_order(MODE_ASK, 32'h5, 32'h5, 1'b0);
      f.time_id = 32'h0;
      send_item(f);
      f.mode = MODE_UNUSED;
      send_item(f);
    end
    send_item(make_order(MODE_RUN, '0, '0, 1'b0));
    // overflow the ask side
    for (int i = 0; i < SLOTS + 1; i++)
      send_item(make_order(MODE_ASK, i << 16, 32'h1_0000, 1'b0));
    send_item(make_order(MODE_RUN, '0, '0, 1'b0));
    drain();

    // random phases with different register settings
    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 72 : 0;
      recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 17 : 0;
      cfg_write(CFG_PRODUCT, (ph == 2) ? 32'h0 : $urandom_range(255));
      cfg_write(CFG_TIME, (ph == 2) ? 32'h0 : $urandom);
      for (int b = 0; b < 5; b++) begin
        int n;
        n = (b == 4) ? 2 * SLOTS + 2 : $urandom_range(1, 14);
        rand_batch(n);
        sent += n + 1;
      end
      drain();
    end

    // receiver held off while orders keep coming
    fork
      begin
        hold_recv = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      begin
        for (int b = 0; b < 3; b++) rand_batch(SLOTS);
        in_valid_i <= 1'b0;
      end
    join
    drain();
    if (book.errors == 0 && book.sales_due.size() == 0)
      $display("PASS order_crossing_match_engine_top");
    else
      $display("FAIL order_crossing_match_engine_top");
    $finish;
  end

endmodule
